// ===== rtl/core/acf_pkg.sv =====
// shared types, code page codes and the fold table for the ascii fold core
// no dependencies; imported by every module of the core
package acf_pkg;

	// code page of a unit, picked from its high byte
	typedef enum logic [2:0] {
		PAGE_NONE,
		PAGE_LATIN1,
		PAGE_SPACING,
		PAGE_COMBINING,
		PAGE_PUNCT,
		PAGE_CJK,
		PAGE_FULLWIDTH
	} page_t;

	// ascii replacement characters
	localparam logic [6:0] CH_DQUOTE   = 7'h22;
	localparam logic [6:0] CH_SQUOTE   = 7'h27;
	localparam logic [6:0] CH_BACKTICK = 7'h60;
	localparam logic [6:0] CH_UP_A     = 7'h41;
	localparam logic [6:0] CH_UP_C     = 7'h43;
	localparam logic [6:0] CH_UP_D     = 7'h44;
	localparam logic [6:0] CH_UP_E     = 7'h45;
	localparam logic [6:0] CH_UP_I     = 7'h49;
	localparam logic [6:0] CH_UP_N     = 7'h4E;
	localparam logic [6:0] CH_UP_O     = 7'h4F;
	localparam logic [6:0] CH_UP_U     = 7'h55;
	localparam logic [6:0] CH_UP_X     = 7'h58;
	localparam logic [6:0] CH_UP_Y     = 7'h59;
	localparam logic [6:0] CH_LO_A     = 7'h61;
	localparam logic [6:0] CH_LO_C     = 7'h63;
	localparam logic [6:0] CH_LO_E     = 7'h65;
	localparam logic [6:0] CH_LO_I     = 7'h69;
	localparam logic [6:0] CH_LO_N     = 7'h6E;
	localparam logic [6:0] CH_LO_O     = 7'h6F;
	localparam logic [6:0] CH_LO_S     = 7'h73;
	localparam logic [6:0] CH_LO_U     = 7'h75;

	// result of one table lookup
	typedef struct packed {
		logic       hit;
		logic       two;
		logic [6:0] first;
		logic [6:0] second;
	} fold_hit_t;

	// stage 1 contents: page code plus the raw unit
	typedef struct packed {
		page_t       page;
		logic [15:0] unit;
		logic        eos;
	} s1_t;

	// stage 2 contents: lookup result plus the raw unit
	typedef struct packed {
		fold_hit_t   fold;
		logic [15:0] unit;
		logic        eos;
	} s2_t;

	// single replacement
	function automatic fold_hit_t fold_one(input logic [6:0] ch);
		fold_hit_t r;
		r.hit    = 1'b1;
		r.two    = 1'b0;
		r.first  = ch;
		r.second = '0;
		return r;
	endfunction

	// two-unit expansion
	function automatic fold_hit_t fold_pair(input logic [6:0] ch_a, input logic [6:0] ch_b);
		fold_hit_t r;
		r.hit    = 1'b1;
		r.two    = 1'b1;
		r.first  = ch_a;
		r.second = ch_b;
		return r;
	endfunction

	// fold table, decoded by page and low byte
	function automatic fold_hit_t fold_lookup(input page_t page, input logic [7:0] low);
		fold_hit_t r;
		r = '0;
		case (page)
			PAGE_LATIN1: begin
				case (low) inside
					8'hAB, 8'hBB:                             r = fold_one(CH_DQUOTE);
					8'hB4:                                    r = fold_one(CH_SQUOTE);
					8'hC4:                                    r = fold_pair(CH_UP_A, CH_LO_E);
					8'hD6:                                    r = fold_pair(CH_UP_O, CH_LO_E);
					8'hDC:                                    r = fold_pair(CH_UP_U, CH_LO_E);
					8'hE4:                                    r = fold_pair(CH_LO_A, CH_LO_E);
					8'hF6:                                    r = fold_pair(CH_LO_O, CH_LO_E);
					8'hFC:                                    r = fold_pair(CH_LO_U, CH_LO_E);
					8'hDF:                                    r = fold_pair(CH_LO_S, CH_LO_S);
					[8'hC0:8'hC3], 8'hC5, 8'hC6:              r = fold_one(CH_UP_A);
					8'hC7:                                    r = fold_one(CH_UP_C);
					[8'hC8:8'hCB]:                            r = fold_one(CH_UP_E);
					[8'hCC:8'hCF]:                            r = fold_one(CH_UP_I);
					8'hD0:                                    r = fold_one(CH_UP_D);
					8'hD1:                                    r = fold_one(CH_UP_N);
					[8'hD2:8'hD5], 8'hD8:                     r = fold_one(CH_UP_O);
					8'hD7:                                    r = fold_one(CH_UP_X);
					[8'hD9:8'hDB]:                            r = fold_one(CH_UP_U);
					8'hDD:                                    r = fold_one(CH_UP_Y);
					[8'hE0:8'hE3], 8'hE5, 8'hE6:              r = fold_one(CH_LO_A);
					8'hE7:                                    r = fold_one(CH_LO_C);
					[8'hE8:8'hEB]:                            r = fold_one(CH_LO_E);
					[8'hEC:8'hEF]:                            r = fold_one(CH_LO_I);
					8'hF1:                                    r = fold_one(CH_LO_N);
					[8'hF2:8'hF5], 8'hF8:                     r = fold_one(CH_LO_O);
					[8'hF9:8'hFB]:                            r = fold_one(CH_LO_U);
					default:                                  r = '0;
				endcase
			end
			PAGE_SPACING: begin
				case (low) inside
					8'hB9, 8'hBC, 8'hC8:                      r = fold_one(CH_SQUOTE);
					8'hBA:                                    r = fold_one(CH_DQUOTE);
					8'hCB:                                    r = fold_one(CH_BACKTICK);
					default:                                  r = '0;
				endcase
			end
			PAGE_COMBINING: begin
				case (low) inside
					8'h00:                                    r = fold_one(CH_BACKTICK);
					8'h01:                                    r = fold_one(CH_SQUOTE);
					8'h0B, 8'h0E:                             r = fold_one(CH_DQUOTE);
					default:                                  r = '0;
				endcase
			end
			PAGE_PUNCT: begin
				case (low) inside
					[8'h18:8'h1B], 8'h32, 8'h34, 8'h37:       r = fold_one(CH_SQUOTE);
					[8'h1C:8'h1F], 8'h33, 8'h36:              r = fold_one(CH_DQUOTE);
					8'h35:                                    r = fold_one(CH_BACKTICK);
					default:                                  r = '0;
				endcase
			end
			PAGE_CJK: begin
				case (low) inside
					8'h03, [8'h1D:8'h1F]:                     r = fold_one(CH_DQUOTE);
					default:                                  r = '0;
				endcase
			end
			PAGE_FULLWIDTH: begin
				case (low) inside
					8'h02:                                    r = fold_one(CH_DQUOTE);
					8'h07:                                    r = fold_one(CH_SQUOTE);
					default:                                  r = '0;
				endcase
			end
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/acf_page_decode.sv =====
// stage 1: classifies the high byte of each unit into a code page
// depends on acf_pkg
module acf_page_decode (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [15:0]   in_unit,
	input  logic          in_eos,
	output logic          out_valid,
	input  logic          out_ready,
	output acf_pkg::s1_t  out_data
);
	import acf_pkg::*;

	logic  valid_s1;
	s1_t   data_s1;
	page_t page;

	// page from the high byte; ascii never matches
	always_comb begin
		case (in_unit[15:8])
			8'h00:   page = in_unit[7] ? PAGE_LATIN1 : PAGE_NONE;
			8'h02:   page = PAGE_SPACING;
			8'h03:   page = PAGE_COMBINING;
			8'h20:   page = PAGE_PUNCT;
			8'h30:   page = PAGE_CJK;
			8'hFF:   page = PAGE_FULLWIDTH;
			default: page = PAGE_NONE;
		endcase
	end

	assign in_ready = !valid_s1 || out_ready;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1.page <= page;
			data_s1.unit <= in_unit;
			data_s1.eos  <= in_eos;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;
endmodule

// ===== rtl/core/acf_table_lookup.sv =====
// stage 2: looks up the low byte in the fold table of the decoded page
// depends on acf_pkg
module acf_table_lookup (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  acf_pkg::s1_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output acf_pkg::s2_t  out_data
);
	import acf_pkg::*;

	logic valid_s2;
	s2_t  data_s2;

	assign in_ready = !valid_s2 || out_ready;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	// table decode into the stage register
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s2.fold <= fold_lookup(in_data.page, in_data.unit[7:0]);
			data_s2.unit <= in_data.unit;
			data_s2.eos  <= in_data.eos;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;
endmodule

// ===== rtl/core/acf_expander.sv =====
// stage 3: output register that sends one or two units per item
// depends on acf_pkg
module acf_expander (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  acf_pkg::s2_t  in_data,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [15:0]   m_tdata,
	output logic          m_tlast,
	output logic [0:0]    m_tuser
);
	import acf_pkg::*;

	logic        valid_s3;
	logic        two_s3;
	logic [15:0] unit_s3;
	logic [6:0]  second_s3;
	logic        eos_s3;

	// take a new item once the last unit of the current one leaves
	assign in_ready = !valid_s3 || (m_tready && !two_s3);

	// control: stage valid and pending second unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			two_s3   <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
			two_s3   <= in_valid && in_data.fold.hit && in_data.fold.two;
		end else if (m_tready) begin
			two_s3   <= 1'b0;
		end
	end

	// payload: load an item, or move to the second unit of a pair
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			unit_s3   <= in_data.fold.hit ? {9'b0, in_data.fold.first} : in_data.unit;
			second_s3 <= in_data.fold.second;
			eos_s3    <= in_data.eos;
		end else if (valid_s3 && m_tready && two_s3) begin
			unit_s3   <= {9'b0, second_s3};
		end
	end

	assign m_tvalid   = valid_s3;
	assign m_tdata    = unit_s3;
	assign m_tuser[0] = !two_s3;
	assign m_tlast    = eos_s3 && !two_s3;

	// first unit of a pair is followed by the second
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && m_tready && two_s3 |=> valid_s3 && !two_s3)
		else $error("second unit of an expansion missing");

	// a pair always starts with an ascii unit
	a_pair_ascii: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && two_s3 |-> unit_s3[15:7] == 9'b0)
		else $error("expansion unit is not ascii");

	// a taken item shows on the output next cycle
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s3)
		else $error("loaded item not presented");
endmodule

// ===== rtl/core/ascii_fold_transliterator_core.sv =====
// Folds a stream of UTF-16 code units toward plain ASCII. Each input item is one
// code unit with tlast marking the end of a string. Typographic quotes, accented
// Latin-1 letters, umlauts and sharp s are replaced by one ASCII unit, or by two
// (umlaut -> letter plus 'e', sharp s -> "ss"); every other unit passes through.
// The pipeline has three register stages (page decode, table lookup, output
// register); a taken item passes through them in that order before its result
// is presented. One item is accepted per cycle while the receiver is ready and
// no second unit is pending; an item that expands to two units holds the output
// register until both have left, which pauses input when the pipeline is full.
// m_tuser marks the last result of each item and m_tlast the last result of a
// string. There is no configuration and no internal state besides the stages.
// depends on acf_pkg, acf_page_decode, acf_table_lookup, acf_expander
module ascii_fold_transliterator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,    // [15:0] code_unit
	input  logic        s_tlast,    // end_of_string
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,    // [15:0] out_unit
	output logic        m_tlast,    // string_last
	output logic [0:0]  m_tuser     // [0] run_last
);
	import acf_pkg::*;

	logic valid_s1;
	logic ready_s1;
	s1_t  data_s1;
	logic valid_s2;
	logic ready_s2;
	s2_t  data_s2;

	// stage 1: page decode
	acf_page_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_unit   (s_tdata),
		.in_eos    (s_tlast),
		.out_valid (valid_s1),
		.out_ready (ready_s1),
		.out_data  (data_s1)
	);

	// stage 2: table lookup
	acf_table_lookup u_lookup (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_ready  (ready_s1),
		.in_data   (data_s1),
		.out_valid (valid_s2),
		.out_ready (ready_s2),
		.out_data  (data_s2)
	);

	// stage 3: expansion and output register
	acf_expander u_expand (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s2),
		.in_ready (ready_s2),
		.in_data  (data_s2),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);
endmodule

// ===== verif/acf_fold_checker.sv =====
// checker for the ascii fold core: watches both stream channels and scores every result
// holds its own copy of the fold table; no dependencies besides the channel signals
`timescale 1ns / 100ps

module acf_fold_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,    // [15:0] code_unit
	input  logic        s_tlast,    // end_of_string
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,    // [15:0] out_unit
	input  logic        m_tlast,    // string_last
	input  logic [0:0]  m_tuser,    // [0] run_last
	output int          fail_count,
	output int          pending,
	output int          item_count,
	output int          result_count,
	output int          pair_count,
	output int          string_count
);

	localparam logic [15:0] NO_SECOND = 16'h0000;
	localparam logic [15:0] ASCII_TOP = 16'h0080;

	typedef struct packed {
		logic [15:0] unit;
		logic        run_last;
		logic        string_last;
	} folded_t;

	folded_t folded_q[$];

	// replacement for one code unit as {first, second}; second is zero for a single unit
	function automatic logic [31:0] fold_unit(input logic [15:0] u);
		logic [31:0] r;
		r = {u, NO_SECOND};
		if (u >= ASCII_TOP) begin
			case (u)
				// quote marks
				16'h00AB, 16'h00BB, 16'h02BA, 16'h030B, 16'h030E, 16'h201C, 16'h201D,
				16'h201E, 16'h201F, 16'h2033, 16'h2036, 16'h3003, 16'h301D, 16'h301E,
				16'h301F, 16'hFF02:
					r = {16'h0022, NO_SECOND};
				16'h00B4, 16'h02B9, 16'h02BC, 16'h02C8, 16'h0301, 16'h2018, 16'h2019,
				16'h201A, 16'h201B, 16'h2032, 16'h2034, 16'h2037, 16'hFF07:
					r = {16'h0027, NO_SECOND};
				16'h02CB, 16'h0300, 16'h2035:
					r = {16'h0060, NO_SECOND};
				// umlauts and sharp s expand to two units
				16'h00C4: r = {16'h0041, 16'h0065};
				16'h00D6: r = {16'h004F, 16'h0065};
				16'h00DC: r = {16'h0055, 16'h0065};
				16'h00E4: r = {16'h0061, 16'h0065};
				16'h00F6: r = {16'h006F, 16'h0065};
				16'h00FC: r = {16'h0075, 16'h0065};
				16'h00DF: r = {16'h0073, 16'h0073};
				// upper case letters with diacritics
				16'h00C0, 16'h00C1, 16'h00C2, 16'h00C3, 16'h00C5, 16'h00C6:
					r = {16'h0041, NO_SECOND};
				16'h00C7: r = {16'h0043, NO_SECOND};
				16'h00C8, 16'h00C9, 16'h00CA, 16'h00CB:
					r = {16'h0045, NO_SECOND};
				16'h00CC, 16'h00CD, 16'h00CE, 16'h00CF:
					r = {16'h0049, NO_SECOND};
				16'h00D0: r = {16'h0044, NO_SECOND};
				16'h00D1: r = {16'h004E, NO_SECOND};
				16'h00D2, 16'h00D3, 16'h00D4, 16'h00D5, 16'h00D8:
					r = {16'h004F, NO_SECOND};
				16'h00D7: r = {16'h0058, NO_SECOND};
				16'h00D9, 16'h00DA, 16'h00DB:
					r = {16'h0055, NO_SECOND};
				16'h00DD: r = {16'h0059, NO_SECOND};
				// lower case letters with diacritics
				16'h00E0, 16'h00E1, 16'h00E2, 16'h00E3, 16'h00E5, 16'h00E6:
					r = {16'h0061, NO_SECOND};
				16'h00E7: r = {16'h0063, NO_SECOND};
				16'h00E8, 16'h00E9, 16'h00EA, 16'h00EB:
					r = {16'h0065, NO_SECOND};
				16'h00EC, 16'h00ED, 16'h00EE, 16'h00EF:
					r = {16'h0069, NO_SECOND};
				16'h00F1: r = {16'h006E, NO_SECOND};
				16'h00F2, 16'h00F3, 16'h00F4, 16'h00F5, 16'h00F8:
					r = {16'h006F, NO_SECOND};
				16'h00F9, 16'h00FA, 16'h00FB:
					r = {16'h0075, NO_SECOND};
				default: r = {u, NO_SECOND};
			endcase
		end
		return r;
	endfunction

	// predict on every accepted item, score on every accepted result
	always @(posedge clk or negedge arst_n) begin
		logic [31:0] folded;
		folded_t     got;
		folded_t     want;
		if (!arst_n) begin
			folded_q.delete();
			fail_count   = 0;
			pending      = 0;
			item_count   = 0;
			result_count = 0;
			pair_count   = 0;
			string_count = 0;
		end else begin
			// expected results of the incoming item
			if (s_tvalid && s_tready) begin
				folded = fold_unit(s_tdata);
				item_count++;
				if (s_tlast)
					string_count++;
				if (folded[15:0] != NO_SECOND) begin
					pair_count++;
					folded_q.push_back('{folded[31:16], 1'b0, 1'b0});
					folded_q.push_back('{folded[15:0], 1'b1, s_tlast});
				end else begin
					folded_q.push_back('{folded[31:16], 1'b1, s_tlast});
				end
			end
			// compare the outgoing result with the oldest expectation
			if (m_tvalid && m_tready) begin
				got = '{m_tdata, m_tuser[0], m_tlast};
				result_count++;
				if (folded_q.size() == 0) begin
					$error("unexpected result: out_unit %h run_last %b string_last %b",
						got.unit, got.run_last, got.string_last);
					fail_count++;
				end else begin
					want = folded_q.pop_front();
					if (got.unit !== want.unit) begin
						$error("out_unit: expected %h, actual %h", want.unit, got.unit);
						fail_count++;
					end
					if (got.run_last !== want.run_last) begin
						$error("run_last: expected %b, actual %b", want.run_last, got.run_last);
						fail_count++;
					end
					if (got.string_last !== want.string_last) begin
						$error("string_last: expected %b, actual %b",
							want.string_last, got.string_last);
						fail_count++;
					end
				end
			end
			pending = folded_q.size();
		end
	end

endmodule

// ===== verif/tb.sv =====
// top of the ascii fold testbench: clock, reset, stimulus and verdict
// depends on ascii_fold_transliterator_core and acf_fold_checker
`timescale 1ns / 100ps

module tb;

	localparam int ITEMS_PER_PHASE = 225;
	localparam int DRAIN_GUARD     = 20000;
	localparam int TAIL_CYCLES     = 8;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;    // [15:0] code_unit
	logic        s_tlast;    // end_of_string
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;    // [15:0] out_unit
	logic        m_tlast;    // string_last
	logic [0:0]  m_tuser;    // [0] run_last

	int fail_count;
	int pending;
	int item_count;
	int result_count;
	int pair_count;
	int string_count;

	// idle and stall percentages of the current phase, plus the receiver hold-off request
	int idle_pct;
	int stall_pct;
	bit hold_req;
	int hold_len;
	int phase_items;

	ascii_fold_transliterator_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	acf_fold_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tlast      (s_tlast),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast),
		.m_tuser      (m_tuser),
		.fail_count   (fail_count),
		.pending      (pending),
		.item_count   (item_count),
		.result_count (result_count),
		.pair_count   (pair_count),
		.string_count (string_count)
	);

	// 8 ns clock
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// run limit
	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

	// receiver: random stalls, or one long hold-off counted here
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (hold_len) @(negedge clk);
				hold_req = 1'b0;
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// code unit biased toward the table pages, with ascii and full range mixed in
	function automatic logic [15:0] pick_unit();
		int sel;
		sel = $urandom_range(99);
		if (sel < 35)
			return 16'($urandom_range(16'h00FF, 16'h00A0));
		else if (sel < 45)
			return 16'($urandom_range(16'h030F, 16'h02B0));
		else if (sel < 55)
			return 16'($urandom_range(16'h203F, 16'h2010));
		else if (sel < 60)
			return 16'($urandom_range(16'h301F, 16'h3000));
		else if (sel < 65)
			return 16'($urandom_range(16'hFF0F, 16'hFF00));
		else if (sel < 85)
			return 16'($urandom_range(16'h007F, 16'h0000));
		return 16'($urandom);
	endfunction

	// offer one item after random idle cycles; returns at the falling edge after acceptance
	task automatic send_unit(input logic [15:0] unit, input logic eos);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 16'($urandom);
			s_tlast  <= 1'($urandom);
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= unit;
		s_tlast  <= eos;
		do @(posedge clk); while (!s_tready);
		phase_items++;
		@(negedge clk);
	endtask

	// one string of random length; a broken one carries random end flags
	task automatic send_string(input int len, input bit broken);
		int k;
		for (k = 0; k < len; k++)
			send_unit(pick_unit(), broken ? 1'($urandom_range(1)) : (k == len - 1));
	endtask

	// sender pause until every expected result has arrived
	task automatic wait_drained();
		int guard;
		guard = 0;
		s_tvalid <= 1'b0;
		while (pending != 0 && guard < DRAIN_GUARD) begin
			@(negedge clk);
			guard++;
		end
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	// stimulus and verdict
	initial begin
		int phase;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = 16'h0000;
		s_tlast     = 1'b0;
		idle_pct    = 0;
		stall_pct   = 0;
		hold_req    = 1'b0;
		hold_len    = 0;
		phase_items = 0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: end flag with no string before it, back to back end flags
		send_unit(16'h0000, 1'b1);
		send_unit(16'hFFFF, 1'b1);
		// ascii edge and first non-ascii unit outside the table
		send_unit(16'h007F, 1'b0);
		send_unit(16'h0080, 1'b0);
		// two-unit expansions, one of them closing a string
		send_unit(16'h00C4, 1'b0);
		send_unit(16'h00DF, 1'b0);
		send_unit(16'h00FC, 1'b1);
		// single replacements from every page
		send_unit(16'h00AB, 1'b0);
		send_unit(16'h00B4, 1'b0);
		send_unit(16'h02B9, 1'b0);
		send_unit(16'h02CB, 1'b0);
		send_unit(16'h0300, 1'b0);
		send_unit(16'h030E, 1'b0);
		send_unit(16'h2018, 1'b0);
		send_unit(16'h2037, 1'b0);
		send_unit(16'h3003, 1'b0);
		send_unit(16'h301F, 1'b0);
		send_unit(16'hFF02, 1'b0);
		send_unit(16'hFF07, 1'b1);
		// gaps inside the table ranges and surrogates pass through
		send_unit(16'h00F0, 1'b0);
		send_unit(16'h00F7, 1'b0);
		send_unit(16'h00FF, 1'b0);
		send_unit(16'hD800, 1'b0);
		send_unit(16'hDFFF, 1'b1);
		wait_drained();

		// random strings over four idle profiles
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 54; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 54; end
				default: begin idle_pct = 33; stall_pct = 33; end
			endcase
			phase_items = 0;
			// long receiver hold-off while the sender keeps offering
			if (phase == 0 || phase == 2) begin
				hold_len = $urandom_range(200, 120);
				hold_req = 1'b1;
			end
			while (phase_items < ITEMS_PER_PHASE)
				send_string($urandom_range(12, 1), $urandom_range(9) == 0);
			wait_drained();
		end

		$display("covered %0d items in %0d strings over four idle profiles with hold-offs",
			item_count, string_count);
		$display("checked %0d results, %0d items expanded to two units",
			result_count, pair_count);
		if (fail_count == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
